// ===== hw/rtl/dfm_pkg.sv =====
// ----------------------------------------------------------------------------
// Depth flatness mask package
// Fixed-point constants, field widths, register codes and shared types.
// ----------------------------------------------------------------------------
package dfm_pkg;

   // Fixed point with FRAC_BITS fraction bits; one unit is 2**FRAC_BITS.
   localparam int FRAC_BITS     = 4;
   localparam int RAW_W         = 16;
   localparam int WIDTH_REG_W   = 10;
   localparam int MASK_COL_W    = 9;
   localparam int MASK_ROW_W    = 10;

   localparam int NEAR_INT      = -(600 * (2 ** FRAC_BITS));
   localparam int FAR_INT       = 600 * (2 ** FRAC_BITS);
   localparam int BAND_INT      = -(400 * (2 ** FRAC_BITS));
   localparam int SPAN_INT      = 1200 * (2 ** FRAC_BITS);
   localparam int SUM_LIMIT_INT = 80 * (2 ** FRAC_BITS);

   // Mapped value width, quotient width and product width.
   localparam int VAL_W  = $clog2(FAR_INT + 1) + 1;
   localparam int QUO_W  = $clog2(SPAN_INT);
   localparam int PROD_W = RAW_W + QUO_W;
   localparam int SUM_W  = VAL_W + 3;

   typedef logic signed [VAL_W-1:0] val_type;

   localparam val_type NEAR_VAL = val_type'(NEAR_INT);
   localparam val_type FAR_VAL  = val_type'(FAR_INT);
   localparam val_type BAND_VAL = val_type'(BAND_INT);
   localparam logic [QUO_W-1:0] SPAN_VAL = QUO_W'(SPAN_INT);
   localparam logic [SUM_W-1:0] SUM_LIMIT_VAL = SUM_W'(SUM_LIMIT_INT);

   // Register map: word index taken from paddr[3:2].
   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_NEAR  = 2'd0;
   localparam logic [1:0] REG_FAR   = 2'd1;
   localparam logic [1:0] REG_WIDTH = 2'd2;

   localparam logic [RAW_W-1:0]       NEAR_RESET  = 16'd500;
   localparam logic [RAW_W-1:0]       FAR_RESET   = 16'd6000;
   localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = 10'd512;

   // Window result handed from the window unit to the output stage.
   typedef struct packed {
      logic                  emit;
      logic                  mask_on;
      logic [MASK_COL_W-1:0] mask_col;
      logic [MASK_ROW_W-1:0] mask_row;
   } win_res_type;

endpackage

// ===== hw/rtl/dfm_if.sv =====
// ----------------------------------------------------------------------------
// Depth flatness mask channels
// Valid/ready channels for depth pixel words and mask words.
// ----------------------------------------------------------------------------
interface dfm_req_if;
   import dfm_pkg::*;

   logic             valid;
   logic             ready;
   logic [RAW_W-1:0] raw_depth;
   logic             frame_start;

   modport source (output valid, output raw_depth, output frame_start, input ready);
   modport sink   (input valid, input raw_depth, input frame_start, output ready);
endinterface

interface dfm_rsp_if;
   import dfm_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  mask_on;
   logic [MASK_COL_W-1:0] mask_col;
   logic [MASK_ROW_W-1:0] mask_row;

   modport source (output valid, output mask_on, output mask_col, output mask_row,
                   input ready);
   modport sink   (input valid, input mask_on, input mask_col, input mask_row,
                   output ready);
endinterface

// ===== hw/rtl/dfm_mapper.sv =====
// ----------------------------------------------------------------------------
// Depth mapper
// Maps a raw depth to fixed point with one multiply and a bit-serial divide.
// ----------------------------------------------------------------------------
module dfm_mapper (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [dfm_pkg::RAW_W-1:0]      raw_depth,
   input  logic [dfm_pkg::RAW_W-1:0]      near_limit,
   input  logic [dfm_pkg::RAW_W-1:0]      far_limit,
   output logic                           done,
   output dfm_pkg::val_type               value
);
   import dfm_pkg::*;

   localparam logic [1:0] M_IDLE = 2'd0;
   localparam logic [1:0] M_MUL  = 2'd1;
   localparam logic [1:0] M_DIV  = 2'd2;
   localparam logic [1:0] M_DONE = 2'd3;
   localparam int STEP_W = $clog2(QUO_W);

   logic [1:0]        state_ff, state_in;
   logic [RAW_W-1:0]  diff_ff, diff_in;
   logic [RAW_W-1:0]  den_ff, den_in;
   logic [RAW_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   val_type           value_ff, value_in;

   logic [PROD_W-1:0] prod;
   logic [RAW_W:0]    trial;
   logic              fits;
   logic [RAW_W-1:0]  rem_next;
   logic [QUO_W-1:0]  quo_next;

   assign prod     = PROD_W'(diff_ff) * PROD_W'(SPAN_VAL);
   // One restoring step: bring down the next numerator bit, subtract if it fits.
   assign trial    = {rem_ff, quo_ff[QUO_W-1]};
   assign fits     = trial >= {1'b0, den_ff};
   assign rem_next = fits ? RAW_W'(trial - {1'b0, den_ff}) : RAW_W'(trial);
   assign quo_next = {quo_ff[QUO_W-2:0], fits};

   always_comb begin
      state_in = state_ff;
      diff_in  = diff_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      value_in = value_ff;
      case (state_ff)
         M_IDLE: begin
            if (start) begin
               diff_in = raw_depth - near_limit;
               den_in  = far_limit - near_limit;
               if (far_limit <= near_limit || raw_depth <= near_limit) begin
                  value_in = NEAR_VAL;
                  state_in = M_DONE;
               end else if (raw_depth >= far_limit) begin
                  value_in = FAR_VAL;
                  state_in = M_DONE;
               end else begin
                  state_in = M_MUL;
               end
            end
         end
         M_MUL: begin
            rem_in   = prod[PROD_W-1:QUO_W];
            quo_in   = prod[QUO_W-1:0];
            step_in  = STEP_W'(QUO_W - 1);
            state_in = M_DIV;
         end
         M_DIV: begin
            rem_in = rem_next;
            quo_in = quo_next;
            if (step_ff == '0) begin
               value_in = val_type'(NEAR_VAL + val_type'(quo_next));
               state_in = M_DONE;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         M_DONE: begin
            state_in = M_IDLE;
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff  <= diff_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      step_ff  <= step_in;
      value_ff <= value_in;
   end

   assign done  = state_ff == M_DONE;
   assign value = value_ff;

endmodule

// ===== hw/rtl/dfm_window.sv =====
// ----------------------------------------------------------------------------
// Depth flatness window
// Line buffer memory, neighbour registers, raster position and mask test.
// ----------------------------------------------------------------------------
module dfm_window #(
   parameter int MAX_WIDTH = 512
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                pix_start,
   input  logic                                frame_start,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]      width_eff,
   input  logic                                commit,
   input  dfm_pkg::val_type                    cur,
   output dfm_pkg::win_res_type                res
);
   import dfm_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int CNT_W = $clog2(MAX_WIDTH + 1);

   val_type line_mem [MAX_WIDTH];

   logic [COL_W-1:0]      col_ff, col_in;
   logic [MASK_ROW_W-1:0] row_ff, row_in;
   val_type               left_ff, left_in;
   val_type               above_left_ff, above_left_in;
   logic [COL_W-1:0]      pcol_ff;
   logic [MASK_ROW_W-1:0] prow_ff;
   val_type               up_ff;

   logic [COL_W-1:0]      pos_col;
   logic [MASK_ROW_W-1:0] pos_row;
   logic                  row_end;
   logic [VAL_W:0]        mag_e, mag_s, mag_se;
   logic [SUM_W-1:0]      sum;

   function automatic logic [VAL_W:0] abs_diff(val_type a, val_type b);
      logic signed [VAL_W:0] d;
      d = $signed({a[VAL_W-1], a}) - $signed({b[VAL_W-1], b});
      return d[VAL_W] ? (VAL_W+1)'(-d) : (VAL_W+1)'(d);
   endfunction

   assign pos_col = frame_start ? '0 : col_ff;
   assign pos_row = frame_start ? '0 : row_ff;

   // The entry above is read when the pixel is taken and written at commit.
   always_ff @(posedge clock) begin
      if (pix_start) begin
         pcol_ff <= pos_col;
         prow_ff <= pos_row;
         up_ff   <= line_mem[pos_col];
      end
      if (commit) begin
         line_mem[pcol_ff] <= cur;
      end
   end

   assign row_end = ((CNT_W+1)'(pcol_ff) + (CNT_W+1)'(1)) >= (CNT_W+1)'(width_eff);

   always_comb begin
      col_in        = col_ff;
      row_in        = row_ff;
      left_in       = left_ff;
      above_left_in = above_left_ff;
      if (commit) begin
         left_in       = cur;
         above_left_in = up_ff;
         if (row_end) begin
            col_in = '0;
            row_in = prow_ff + MASK_ROW_W'(1);
         end else begin
            col_in = pcol_ff + COL_W'(1);
            row_in = prow_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         left_ff       <= '0;
         above_left_ff <= '0;
      end else begin
         col_ff        <= col_in;
         row_ff        <= row_in;
         left_ff       <= left_in;
         above_left_ff <= above_left_in;
      end
   end

   // Centre is the pixel above-left; the east difference counts twice.
   assign mag_e  = abs_diff(above_left_ff, up_ff);
   assign mag_s  = abs_diff(above_left_ff, left_ff);
   assign mag_se = abs_diff(above_left_ff, cur);
   assign sum    = (SUM_W'(mag_e) << 1) + SUM_W'(mag_s) + SUM_W'(mag_se);

   always_comb begin
      res.emit     = (pcol_ff != '0) && (prow_ff != '0);
      res.mask_on  = (sum < SUM_LIMIT_VAL) && (above_left_ff > NEAR_VAL) &&
                     (above_left_ff < BAND_VAL);
      res.mask_col = MASK_COL_W'(pcol_ff - COL_W'(1));
      res.mask_row = prow_ff - MASK_ROW_W'(1);
   end

endmodule

// ===== hw/rtl/depth_flatness_mask.sv =====
// ----------------------------------------------------------------------------
// Depth flatness mask
// Top level: register port, pixel sequencing and the registered mask output.
// ----------------------------------------------------------------------------
// A depth word inside the near/far range is multiplied, then divided by the
// bit-serial divider (one quotient bit per cycle), and committed before the
// next is taken; clamped depths skip both. The mask word appears on rsp in the
// cycle in which the next depth word can be taken. Reset is synchronous and
// clears the sequencer, counters and neighbour registers and loads the
// register defaults; the line buffer is not cleared and needs no clearing pass.
module depth_flatness_mask #(
   parameter int MAX_WIDTH = 512
) (
   input  logic                                clock,
   input  logic                                reset,
   dfm_req_if.sink                             req_chan,
   dfm_rsp_if.source                           rsp_chan,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [dfm_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);
   import dfm_pkg::*;

   localparam int CNT_W = $clog2(MAX_WIDTH + 1);

   // Sequencer states: waiting for a word, mapping it, committing it.
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_MAP    = 2'd1;
   localparam logic [1:0] ST_COMMIT = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [RAW_W-1:0]       near_ff, near_in;
   logic [RAW_W-1:0]       far_ff, far_in;
   logic [WIDTH_REG_W-1:0] width_ff, width_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   mask_on_ff;
   logic [MASK_COL_W-1:0]  mask_col_ff;
   logic [MASK_ROW_W-1:0]  mask_row_ff;

   logic                   accept;
   logic                   commit;
   logic                   load_rsp;
   logic                   csr_write;
   logic                   map_done;
   val_type                map_value;
   win_res_type            win_res;
   int unsigned            width_int;
   logic [CNT_W-1:0]       width_eff;

   // ------------------------------------------------------------------
   // Register port. Writes land in the access phase; pready is tied high
   // so every access completes without wait states.
   // ------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      near_in  = near_ff;
      far_in   = far_ff;
      width_in = width_ff;
      if (csr_write) begin
         case (paddr[3:2])
            REG_NEAR:  near_in  = pwdata[RAW_W-1:0];
            REG_FAR:   far_in   = pwdata[RAW_W-1:0];
            REG_WIDTH: width_in = pwdata[WIDTH_REG_W-1:0];
            default:   ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_NEAR:  prdata = 32'(near_ff);
         REG_FAR:   prdata = 32'(far_ff);
         REG_WIDTH: prdata = 32'(width_ff);
         default:   prdata = '0;
      endcase
   end

   // The programmed width is held to the range 2 .. MAX_WIDTH before use.
   always_comb begin
      width_int = 32'(width_ff);
      if (width_int < 2) begin
         width_int = 2;
      end else if (width_int > MAX_WIDTH) begin
         width_int = MAX_WIDTH;
      end
      width_eff = CNT_W'(width_int);
   end

   // ------------------------------------------------------------------
   // Sequencer. One depth word is in flight at a time: it is taken in
   // idle, mapped, and then committed to the line buffer. The commit waits
   // only if it carries a mask word and the output register is still full.
   // ------------------------------------------------------------------
   assign req_chan.ready = state_ff == ST_IDLE;
   assign accept         = req_chan.valid && req_chan.ready;
   assign commit         = (state_ff == ST_COMMIT) &&
                           (!win_res.emit || !rsp_valid_ff || rsp_chan.ready);
   assign load_rsp       = commit && win_res.emit;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            if (map_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   dfm_mapper u_mapper (
      .clock      (clock),
      .reset      (reset),
      .start      (accept),
      .raw_depth  (req_chan.raw_depth),
      .near_limit (near_ff),
      .far_limit  (far_ff),
      .done       (map_done),
      .value      (map_value)
   );

   dfm_window #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .pix_start   (accept),
      .frame_start (req_chan.frame_start),
      .width_eff   (width_eff),
      .commit      (commit),
      .cur         (map_value),
      .res         (win_res)
   );

   // ------------------------------------------------------------------
   // Output register. It decouples the mask word from the sequencer so a
   // new depth word can be taken while the previous mask word waits.
   // ------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         near_ff      <= NEAR_RESET;
         far_ff       <= FAR_RESET;
         width_ff     <= WIDTH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         near_ff      <= near_in;
         far_ff       <= far_in;
         width_ff     <= width_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         mask_on_ff  <= win_res.mask_on;
         mask_col_ff <= win_res.mask_col;
         mask_row_ff <= win_res.mask_row;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.mask_on  = mask_on_ff;
   assign rsp_chan.mask_col = mask_col_ff;
   assign rsp_chan.mask_row = mask_row_ff;

`ifndef SYNTHESIS
   a_accept_maps: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_MAP)
      else $error("accepted depth word did not start mapping");

   a_done_in_map: assert property (@(posedge clock) disable iff (reset)
      map_done |-> state_ff == ST_MAP)
      else $error("mapper finished outside the mapping state");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> (!rsp_valid_ff || rsp_chan.ready))
      else $error("mask word overwritten before it was taken");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(load_rsp))
      else $error("mask word appeared without a commit");
`endif

endmodule
